[rtl/at_command_loopback_responder_assert.svh]
// ----------------------------------------------------------------------------
// AT responder assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef AT_COMMAND_LOOPBACK_RESPONDER_ASSERT_SVH
`define AT_COMMAND_LOOPBACK_RESPONDER_ASSERT_SVH

// same-cycle implication
`define ATCLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATCLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/atclr_pkg.sv]
// ----------------------------------------------------------------------------
// atclr_pkg
// Types, character codes and response strings of the AT loopback responder.
// ----------------------------------------------------------------------------
`default_nettype none

package atclr_pkg;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_T   = 8'h54;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_O   = 8'h4F;
  localparam logic [7:0] CH_N   = 8'h4E;
  localparam logic [7:0] CH_E   = 8'h45;
  localparam logic [7:0] CH_K   = 8'h4B;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] LEN_OK      = IDX_W'(6);
  localparam logic [IDX_W-1:0] LEN_CONNECT = IDX_W'(11);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_GOT_A = 2'd1,
    PH_GOT_T = 2'd2
  } atclr_phase_t;

  typedef enum logic [1:0] {
    RESP_NONE    = 2'd0,
    RESP_OK      = 2'd1,
    RESP_CONNECT = 2'd2
  } atclr_resp_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    atclr_resp_t resp;
    logic        req_end;
    logic        link_up;
    logic        link_changed;
  } atclr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } atclr_qstat_t;

  function automatic logic is_char(input logic [7:0] c, input logic [7:0] upper);
    return (c == upper) || (c == (upper + CASE_OFS));
  endfunction

  function automatic logic [IDX_W-1:0] resp_len(input atclr_resp_t kind);
    logic [IDX_W-1:0] len;
    unique case (kind)
      RESP_OK:      len = LEN_OK;
      RESP_CONNECT: len = LEN_CONNECT;
      default:      len = '0;
    endcase
    return len;
  endfunction

  // pos counts from 0 within the response string
  function automatic logic [7:0] resp_byte(input atclr_resp_t kind,
                                           input logic [IDX_W-1:0] pos);
    logic [7:0] b;
    b = CH_LF;
    if (kind == RESP_CONNECT) begin
      case (pos)
        4'd0:    b = CH_CR;
        4'd1:    b = CH_LF;
        4'd2:    b = CH_C;
        4'd3:    b = CH_O;
        4'd4:    b = CH_N;
        4'd5:    b = CH_N;
        4'd6:    b = CH_E;
        4'd7:    b = CH_C;
        4'd8:    b = CH_T;
        4'd9:    b = CH_CR;
        default: b = CH_LF;
      endcase
    end else begin
      case (pos)
        4'd0:    b = CH_CR;
        4'd1:    b = CH_LF;
        4'd2:    b = CH_O;
        4'd3:    b = CH_K;
        4'd4:    b = CH_CR;
        default: b = CH_LF;
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/atclr_if.sv]
// ----------------------------------------------------------------------------
// atclr_if
// Valid/ready channels of the AT loopback responder: host bytes in, read bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface atclr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       request_end;

  modport source (output valid, output data_byte, output request_end, input ready);
  modport sink   (input valid, input data_byte, input request_end, output ready);
endinterface

interface atclr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       request_done;
  logic       connected;
  logic       connect_changed;

  modport source (output valid, output out_byte, output last_of_run,
                  output request_done, output connected, output connect_changed,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input request_done, input connected, input connect_changed,
                  output ready);
endinterface

`default_nettype wire

[rtl/at_command_loopback_responder.sv]
// ----------------------------------------------------------------------------
// at_command_loopback_responder
// Loopback modem: echoes host bytes and answers AT commands with OK or CONNECT.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_ch    | in  | valid/ready        | data_byte[7:0], request_end
//  out_ch   | out | valid/ready        | out_byte[7:0], last_of_run, request_done,
//           |     |                    | connected, connect_changed
//
//  One item per cycle into a two-entry command queue; plain bytes leave one per
//  cycle while out_ready is high. A carriage return ending an AT command holds
//  the output side while its OK or CONNECT string plays out; input keeps flowing
//  until the queue fills, then stalls. Results leave through one output register
//  behind the queue. NUL bytes are taken and dropped without a result.
//  Reset is synchronous; state is usable the cycle after rst_n rises.
// ----------------------------------------------------------------------------
`default_nettype none

module at_command_loopback_responder
  import atclr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  atclr_in_if.sink    in_ch,
  atclr_out_if.source out_ch
);

  logic         push, pop;
  atclr_cmd_t   push_cmd, head_cmd;
  atclr_qstat_t q_stat;

  atclr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_data_byte   (in_ch.data_byte),
    .in_request_end (in_ch.request_end),
    .q_stat         (q_stat),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  atclr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  atclr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_cmd            (head_cmd),
    .q_stat              (q_stat),
    .pop                 (pop),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_byte            (out_ch.out_byte),
    .out_last_of_run     (out_ch.last_of_run),
    .out_request_done    (out_ch.request_done),
    .out_connected       (out_ch.connected),
    .out_connect_changed (out_ch.connect_changed)
  );

endmodule

`default_nettype wire

[rtl/atclr_front.sv]
// ----------------------------------------------------------------------------
// atclr_front
// Accepts host bytes, runs the AT matcher and queues one command per non-NUL byte.
// ----------------------------------------------------------------------------
`default_nettype none

module atclr_front
  import atclr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_request_end,
  input  wire atclr_qstat_t q_stat,
  output logic              push,
  output atclr_cmd_t        push_cmd
);

  atclr_phase_t phase_r, phase_nxt;
  logic         pending_r, pending_nxt;
  logic         skip_r, skip_nxt;
  logic         link_up_r, link_up_nxt;
  logic         link_chg_r, link_chg_nxt;
  logic         take;
  logic         is_cr;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready && (in_data_byte != CH_NUL);
  assign is_cr    = (in_data_byte == CH_CR);

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    pending_nxt  = pending_r;
    skip_nxt     = skip_r;
    link_up_nxt  = link_up_r;
    link_chg_nxt = link_chg_r;
    if (take) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (is_char(in_data_byte, CH_A)) begin
            phase_nxt   = PH_GOT_A;
            pending_nxt = 1'b0;
            skip_nxt    = 1'b0;
          end
        end
        PH_GOT_A: begin
          phase_nxt = is_char(in_data_byte, CH_T) ? PH_GOT_T : PH_IDLE;
        end
        PH_GOT_T: begin
          if (!skip_r && (is_char(in_data_byte, CH_A) || is_char(in_data_byte, CH_D)))
            pending_nxt = 1'b1;
          skip_nxt = 1'b1;
          if (is_cr) begin
            phase_nxt = PH_IDLE;
            if (pending_nxt) begin
              link_up_nxt  = 1'b1;
              link_chg_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    push                  = take;
    push_cmd.data_byte    = in_data_byte;
    push_cmd.req_end      = in_request_end;
    push_cmd.link_up      = link_up_nxt;
    push_cmd.link_changed = link_chg_nxt;
    push_cmd.resp         = RESP_NONE;
    if ((phase_r == PH_GOT_T) && is_cr)
      push_cmd.resp = pending_nxt ? RESP_CONNECT : RESP_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pending_r  <= 1'b0;
      skip_r     <= 1'b0;
      link_up_r  <= 1'b0;
      link_chg_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      pending_r  <= pending_nxt;
      skip_r     <= skip_nxt;
      link_up_r  <= link_up_nxt;
      link_chg_r <= link_chg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/atclr_queue.sv]
// ----------------------------------------------------------------------------
// atclr_queue
// Short command queue between the matcher front and the output back.
// ----------------------------------------------------------------------------
`default_nettype none

module atclr_queue
  import atclr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire atclr_cmd_t push_cmd,
  input  wire logic       pop,
  output atclr_cmd_t      head_cmd,
  output atclr_qstat_t    q_stat
);

  atclr_cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       count_r, count_nxt;

  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_cmd     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push)
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push)
      entry_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/atclr_back.sv]
// ----------------------------------------------------------------------------
// atclr_back
// Plays out each queued command: the echo byte, then any response string.
// ----------------------------------------------------------------------------
`default_nettype none

module atclr_back
  import atclr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire atclr_cmd_t   head_cmd,
  input  wire atclr_qstat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last_of_run,
  output logic              out_request_done,
  output logic              out_connected,
  output logic              out_connect_changed
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r;
  logic             last_r, done_r, conn_r, chg_r;
  logic             advance, load, last;
  logic [7:0]       cur_byte;

  assign advance = !valid_r || out_ready;
  assign load    = advance && !q_stat.empty;

  // idx 0 is the echo, idx n is response byte n-1, counted from 0
  always_comb begin
    if (idx_r == '0) begin
      cur_byte = head_cmd.data_byte;
      last     = (head_cmd.resp == RESP_NONE);
    end else begin
      cur_byte = resp_byte(head_cmd.resp, idx_r - 1'b1);
      last     = (idx_r == resp_len(head_cmd.resp));
    end
    pop     = load && last;
    idx_nxt = idx_r;
    if (load)
      idx_nxt = last ? '0 : idx_r + 1'b1;
    valid_nxt = load ? 1'b1 : (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= last;
      done_r <= last && head_cmd.req_end;
      conn_r <= head_cmd.link_up;
      chg_r  <= head_cmd.link_changed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_byte            = byte_r;
  assign out_last_of_run     = last_r;
  assign out_request_done    = done_r;
  assign out_connected       = conn_r;
  assign out_connect_changed = chg_r;

endmodule

`default_nettype wire

[rtl/atclr_checker.sv]
// ----------------------------------------------------------------------------
// atclr_checker
// Port-level checks on the responder's read side, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "at_command_loopback_responder_assert.svh"

module atclr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last_of_run,
  input wire logic out_request_done,
  input wire logic out_connected,
  input wire logic out_connect_changed
);

  `ATCLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output dropped while stalled")
  `ATCLR_ASSERT_NOW(a_done_last, out_valid && out_request_done, out_last_of_run, "request_done off run end")
  `ATCLR_ASSERT_NOW(a_chg_conn, out_valid && out_connect_changed, out_connected, "changed without connected")
  `ATCLR_ASSERT_NEXT(a_conn_sticky, out_valid && out_connected, !out_valid || out_connected, "connected fell")
  `ATCLR_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !out_last_of_run, out_valid, "run broken")

endmodule

bind at_command_loopback_responder atclr_checker u_atclr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_last_of_run     (out_ch.last_of_run),
  .out_request_done    (out_ch.request_done),
  .out_connected       (out_ch.connected),
  .out_connect_changed (out_ch.connect_changed)
);

`default_nettype wire
